// ===== rtl/sedf_pkg.sv =====
package sedf_pkg;

   // Received byte and frame length widths.
   localparam int ByteW   = 8;
   localparam int LengthW = 17;

   // Framing bytes and fixed sizes.
   localparam logic [7:0]  StxByte     = 8'h02;
   localparam logic [7:0]  EtxByte     = 8'h03;
   localparam logic [23:0] MagicTail   = 24'h020202;
   localparam logic [32:0] BinOverhead = 33'd9;
   // Magic word plus the four length bytes.
   localparam logic [32:0] HeaderBytes = 33'd8;
   localparam logic [LengthW-1:0] LenFieldEnd = 17'd8;
   localparam logic [LengthW-1:0] MagicBytes  = 17'd4;
   localparam logic [LengthW-1:0] MinFrameLen = 17'd16;
   localparam int MaxFrameLen = 65536;

   // Configuration register indexes.
   localparam logic CsrProtocolMode  = 1'b0;
   localparam logic CsrMaxFrameLen   = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ASCII_BODY,
      PH_BIN_LEN,
      PH_BIN_PAYLOAD,
      PH_BIN_CHECK
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BADSUM  = 2'd1,
      ST_TOOLONG = 2'd2
   } status_type;

   // One parser result for the output register.
   typedef struct packed {
      logic               emit;
      logic [ByteW-1:0]   data_byte;
      logic               start_of_frame;
      logic               end_of_frame;
      status_type         frame_status;
      logic [LengthW-1:0] frame_length;
   } result_type;

endpackage

// ===== rtl/sedf_parser.sv =====
module sedf_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         advance,
   input  logic                         protocol_mode,
   input  logic [sedf_pkg::LengthW-1:0] frame_limit,
   input  logic [sedf_pkg::ByteW-1:0]   rx_byte,
   output sedf_pkg::result_type         result
);
   import sedf_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [23:0]        hist_ff, hist_in;
   logic [LengthW-1:0] count_ff, count_in;
   logic [31:0]        pay_ff, pay_in;
   logic [7:0]         xor_ff, xor_in;

   logic [LengthW-1:0] count_inc;
   logic [31:0]        len_shift;
   logic               len_over;
   logic               pay_end;
   logic               at_limit;
   logic               over_limit;
   logic               len_done;
   logic               magic_hit;
   logic               fin;
   status_type         fin_status;

   assign count_inc  = count_ff + 1'b1;
   assign len_shift  = {pay_ff[23:0], rx_byte};
   assign len_over   = ({1'b0, len_shift} + BinOverhead) > {16'b0, frame_limit};
   assign pay_end    = {16'b0, count_inc} >= ({1'b0, pay_ff} + HeaderBytes);
   assign at_limit   = count_inc >= frame_limit;
   assign over_limit = count_inc > frame_limit;
   assign len_done   = count_inc >= LenFieldEnd;
   assign magic_hit  = (rx_byte == StxByte) && (hist_ff == MagicTail);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (!protocol_mode && rx_byte == StxByte) begin
               phase_in = PH_ASCII_BODY;
            end else if (protocol_mode && magic_hit) begin
               phase_in = PH_BIN_LEN;
            end
         end
         PH_ASCII_BODY: begin
            if (rx_byte == EtxByte || at_limit) begin
               phase_in = PH_HUNT;
            end
         end
         PH_BIN_LEN: begin
            if (at_limit || (len_done && len_over)) begin
               phase_in = PH_HUNT;
            end else if (len_done) begin
               phase_in = (len_shift == 32'd0) ? PH_BIN_CHECK : PH_BIN_PAYLOAD;
            end
         end
         PH_BIN_PAYLOAD: begin
            if (at_limit) begin
               phase_in = PH_HUNT;
            end else if (pay_end) begin
               phase_in = PH_BIN_CHECK;
            end
         end
         PH_BIN_CHECK: phase_in = PH_HUNT;
         default:      phase_in = PH_HUNT;
      endcase
   end

   // Datapath state and the result for this byte.
   always_comb begin
      hist_in    = hist_ff;
      count_in   = count_ff;
      pay_in     = pay_ff;
      xor_in     = xor_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      result     = '{emit: 1'b0, data_byte: rx_byte, start_of_frame: 1'b0,
                     end_of_frame: 1'b0, frame_status: ST_OK, frame_length: '0};
      unique case (phase_ff)
         PH_HUNT: begin
            if (!protocol_mode && rx_byte == StxByte) begin
               hist_in  = '0;
               count_in = 17'd1;
               pay_in   = '0;
               xor_in   = '0;
               result.emit           = 1'b1;
               result.start_of_frame = 1'b1;
            end else if (protocol_mode && magic_hit) begin
               hist_in  = '0;
               count_in = MagicBytes;
               pay_in   = '0;
               xor_in   = '0;
               result.emit           = 1'b1;
               result.start_of_frame = 1'b1;
            end else if (protocol_mode) begin
               hist_in = {hist_ff[15:0], rx_byte};
            end
         end
         PH_ASCII_BODY: begin
            count_in    = count_inc;
            result.emit = 1'b1;
            if (rx_byte == EtxByte) begin
               fin        = 1'b1;
               fin_status = over_limit ? ST_TOOLONG : ST_OK;
            end else if (at_limit) begin
               fin        = 1'b1;
               fin_status = ST_TOOLONG;
            end
         end
         PH_BIN_LEN: begin
            count_in    = count_inc;
            pay_in      = len_shift;
            result.emit = 1'b1;
            if (at_limit || (len_done && len_over)) begin
               fin        = 1'b1;
               fin_status = ST_TOOLONG;
            end
         end
         PH_BIN_PAYLOAD: begin
            count_in    = count_inc;
            xor_in      = xor_ff ^ rx_byte;
            result.emit = 1'b1;
            if (at_limit) begin
               fin        = 1'b1;
               fin_status = ST_TOOLONG;
            end
         end
         PH_BIN_CHECK: begin
            result.emit = 1'b1;
            fin         = 1'b1;
            if (over_limit) begin
               fin_status = ST_TOOLONG;
            end else begin
               fin_status = (rx_byte == xor_ff) ? ST_OK : ST_BADSUM;
            end
         end
         default: begin
            result.emit = 1'b0;
         end
      endcase

      // A finished frame reports its length and starts the hunt from zero.
      if (fin) begin
         result.end_of_frame = 1'b1;
         result.frame_status = fin_status;
         result.frame_length = count_inc;
         hist_in  = '0;
         count_in = '0;
         pay_in   = '0;
         xor_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff <= PH_HUNT;
         hist_ff  <= '0;
         count_ff <= '0;
         pay_ff   <= '0;
         xor_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hist_ff  <= hist_in;
         count_ff <= count_in;
         pay_ff   <= pay_in;
         xor_ff   <= xor_in;
      end
   end

endmodule

// ===== rtl/stx_etx_or_length_prefixed_deframer.sv =====
// Byte-stream deframer. Received bytes enter one per word on the req_ channel
// and frame bytes leave one per word on the rsp_ channel; bytes outside a
// frame are dropped. With protocol_mode 0 a frame runs from STX (0x02) up to
// and including ETX (0x03). With protocol_mode 1 the block hunts for the magic
// word 02 02 02 02, reads a 4-byte big-endian payload length, the payload and
// one checksum byte that must equal the XOR of the payload; only the last
// magic byte is passed on. rsp_tuser marks the first word of a frame and
// rsp_tlast its last word, which also carries the status (ok, bad checksum,
// too long) and the frame length with all markers counted. The frame limit is
// max_frame_length held within 16 and the smaller of 65536 and BUFFER_BYTES.
// Each byte waits in an input register while the parser, combinational logic
// over its frame state, works out its word; the word, if any, is registered
// when the byte moves on. A new byte is taken every cycle while the output
// register is empty or being drained, so the block sustains one word per
// cycle; throughput is set only by the output register being drained. Writing
// protocol_mode drops any frame in progress without a result; configuration
// is to be written while the block is idle, which the block does not enforce.
module stx_etx_or_length_prefixed_deframer #(
   parameter int BUFFER_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   // Received bytes. tdata: rx_byte[7:0].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Frame bytes. tdata: data_byte[7:0], frame_status[9:8],
   // frame_length[26:10], zeros above. tuser: start_of_frame. tlast: end_of_frame.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   // Configuration writes.
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   import sedf_pkg::*;

   // Upper bound of the frame limit.
   localparam int LimitCap = (BUFFER_BYTES < MaxFrameLen) ? BUFFER_BYTES : MaxFrameLen;
   localparam logic [LengthW-1:0] LimitMax = LengthW'(LimitCap);

   logic               mode_ff, mode_in;
   logic [LengthW-1:0] limit_ff, limit_in;
   logic               mode_write;

   logic               in_valid_ff;
   logic [ByteW-1:0]   in_byte_ff;
   logic               advance;

   result_type         result;
   logic               out_valid_ff;
   logic [ByteW-1:0]   out_byte_ff;
   logic               out_sof_ff;
   logic               out_eof_ff;
   status_type         out_status_ff;
   logic [LengthW-1:0] out_len_ff;

   // Configuration: the limit is held in range when it is written.
   assign mode_write = csr_wr_en && (csr_index == CsrProtocolMode);
   assign mode_in    = csr_wdata[0];

   always_comb begin
      if (csr_wdata < MinFrameLen) begin
         limit_in = MinFrameLen;
      end else if (csr_wdata > LimitMax) begin
         limit_in = LimitMax;
      end else begin
         limit_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         limit_ff <= LimitMax;
      end else if (csr_wr_en) begin
         if (csr_index == CsrProtocolMode) begin
            mode_ff <= mode_in;
         end else if (csr_index == CsrMaxFrameLen) begin
            limit_ff <= limit_in;
         end
      end
   end

   // The byte in the input register moves on whenever the output register
   // is empty or being drained; a new byte is taken in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   sedf_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .clear         (mode_write),
      .advance       (advance),
      .protocol_mode (mode_ff),
      .frame_limit   (limit_ff),
      .rx_byte       (in_byte_ff),
      .result        (result)
   );

   // Output register. A hunted byte that gives no word leaves it empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         out_byte_ff   <= result.data_byte;
         out_sof_ff    <= result.start_of_frame;
         out_eof_ff    <= result.end_of_frame;
         out_status_ff <= result.frame_status;
         out_len_ff    <= result.frame_length;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_len_ff, out_status_ff, out_byte_ff};
   assign rsp_tuser  = out_sof_ff;
   assign rsp_tlast  = out_eof_ff;

endmodule

// ===== rtl/sedf_checker.sv =====
module sedf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Status and length are zero on every word that does not end a frame.
   a_mid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[31:8] == 24'd0)
      else $error("status or length set on a word inside a frame");

   // A frame start never ends that frame on the same word.
   a_sof_not_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tlast))
      else $error("start and end marked on one word");

   // An end word carries a defined status and counts at least two bytes.
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[9:8] != 2'd3
         && rsp_tdata[26:11] != 16'd0 && rsp_tdata[31:27] == 5'd0)
      else $error("bad status or length on a frame end");

endmodule

bind stx_etx_or_length_prefixed_deframer sedf_checker u_sedf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/tb.sv =====
// Testbench for the STX/ETX or length-prefixed deframer.
//
// Received bytes go in one word per handshake on the req_ channel. Every
// accepted byte is run through a behavioral deframer kept in this file, and
// the frame word that it predicts, if any, is queued. Each word that the block
// hands out on the rsp_ channel is compared field by field with the oldest
// queued word.
//
// The run opens with a short directed table: extreme byte values, both
// framing modes, a checksum error, a too-long length field and a mode switch
// in the middle of a frame. Then come random phases, each with its own frame
// limit; all but every fourth write the mode as well. Most random bytes form
// frames with random content. The rest is line noise, broken magic words,
// truncated frames and lengths at or just past the limit. The receiver idles
// in random bursts except in the last phase, and the sender in most others.
// Once the receiver holds off for a long stretch so that the block backs up
// into its input, and once the sender waits until every frame word is back.
module tb;
   import sedf_pkg::*;

   localparam int BufferBytes   = 65536;
   // Two pipeline stages inside the block; the extra wait lets a byte that makes
   // no word clear the pipeline before a register write.
   localparam int SettleCycles  = 6;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 2000;
   localparam int PhaseCount    = 12;
   localparam int PhaseBytes    = 130;

   // One frame word as the block hands it out.
   typedef struct {
      logic [7:0]  data;
      logic        sof;
      logic        eof;
      status_type  st;
      logic [16:0] len;
   } frame_word_type;

   // A row of the directed table: either a register write or a byte, the
   // byte optionally with the word that it must produce typed in.
   typedef struct {
      bit             is_csr;
      logic           idx;
      logic [16:0]    val;
      logic [7:0]     b;
      bit             typed;
      bit             want_has;
      frame_word_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic        csr_index;
   logic [16:0] csr_wdata;

   // The block under test. The response tdata holds data_byte in [7:0],
   // frame_status in [9:8] and frame_length in [26:10]; tuser marks the start
   // of a frame and tlast its end.
   stx_etx_or_length_prefixed_deframer #(
      .BUFFER_BYTES(BufferBytes)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Period of two time units: high for one, low for one.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ------------------------------------------------------------------
   // Behavioral deframer: our copy of the registers and of the parse state.
   // ------------------------------------------------------------------
   logic        mode_bin    = 1'b0;
   logic [16:0] max_len_reg = 17'd65536;
   phase_type   rx_phase    = PH_HUNT;
   logic [23:0] magic_sr    = '0;
   int unsigned frame_count = 0;
   logic [31:0] len_field   = '0;
   logic [7:0]  xor_sum     = '0;

   frame_word_type frame_words[$];   // words still owed by the block
   frame_word_type no_word;
   stim_row_type   stim_rows[$];
   logic [7:0]     tx_plan[$];

   // Typed-in expectation for the byte now on the input. Set at the same
   // falling edge that puts the byte on req_tdata, so the monitor can never
   // see the value meant for the following byte.
   bit             cur_typed;
   bit             cur_want_has;
   frame_word_type cur_want;

   bit          tx_idle_on;
   bit          rx_idle_on;
   bit          hold_req;

   int unsigned mismatches = 0;
   int unsigned bytes_in   = 0;
   int unsigned words_out  = 0;
   int unsigned n_ok       = 0;
   int unsigned n_badsum   = 0;
   int unsigned n_toolong  = 0;
   int unsigned idle_cycles = 0;

   frame_word_type pred_w;
   bit             pred_has;
   frame_word_type head_w;

   function automatic frame_word_type mk_word(input logic [7:0] b, input logic sof,
                                              input logic eof, input status_type st,
                                              input logic [16:0] len);
      frame_word_type w;
      w.data = b;
      w.sof  = sof;
      w.eof  = eof;
      w.st   = st;
      w.len  = len;
      return w;
   endfunction

   function automatic void clear_frame();
      rx_phase    = PH_HUNT;
      magic_sr    = '0;
      frame_count = 0;
      len_field   = '0;
      xor_sum     = '0;
   endfunction

   // The register value is held within 16 and the smaller of 65536 and the
   // buffer size.
   function automatic int unsigned frame_limit();
      int unsigned l;
      l = {15'd0, max_len_reg};
      if (l < 16) l = 16;
      if (l > 65536) l = 65536;
      if (l > BufferBytes) l = BufferBytes;
      return l;
   endfunction

   // Closing word of a frame; the parser goes back to hunting from scratch.
   function automatic frame_word_type end_word(input logic [7:0] b, input status_type st);
      logic [16:0] len;
      len = frame_count[16:0];
      clear_frame();
      return mk_word(b, 1'b0, 1'b1, st, len);
   endfunction

   // Advances the parse state by one received byte. Returns 1 and the word
   // when the byte belongs to a frame.
   function automatic bit deframe_byte(input logic [7:0] b, output frame_word_type w);
      int unsigned lim;
      lim = frame_limit();
      w = no_word;
      case (rx_phase)
         PH_HUNT: begin
            if (!mode_bin) begin
               if (b != StxByte) return 1'b0;
               clear_frame();
               rx_phase    = PH_ASCII_BODY;
               frame_count = 1;
               w = mk_word(b, 1'b1, 1'b0, ST_OK, '0);
               return 1'b1;
            end
            // Binary: the fourth 0x02 in a row opens the frame and is the
            // only magic byte passed on.
            if (b == StxByte && magic_sr == MagicTail) begin
               clear_frame();
               rx_phase    = PH_BIN_LEN;
               frame_count = 4;
               w = mk_word(b, 1'b1, 1'b0, ST_OK, '0);
               return 1'b1;
            end
            magic_sr = {magic_sr[15:0], b};
            return 1'b0;
         end
         PH_ASCII_BODY: begin
            frame_count++;
            if (b == EtxByte) begin
               w = end_word(b, (frame_count > lim) ? ST_TOOLONG : ST_OK);
               return 1'b1;
            end
            if (frame_count >= lim) begin
               w = end_word(b, ST_TOOLONG);
               return 1'b1;
            end
            w = mk_word(b, 1'b0, 1'b0, ST_OK, '0);
            return 1'b1;
         end
         PH_BIN_LEN: begin
            frame_count++;
            len_field = {len_field[23:0], b};
            if (frame_count >= 8) begin
               // A length that cannot fit ends the frame on its last byte.
               if (longint'(len_field) + 9 > longint'(lim)) begin
                  w = end_word(b, ST_TOOLONG);
                  return 1'b1;
               end
               rx_phase = (len_field == 0) ? PH_BIN_CHECK : PH_BIN_PAYLOAD;
            end
            if (frame_count >= lim) begin
               w = end_word(b, ST_TOOLONG);
               return 1'b1;
            end
            w = mk_word(b, 1'b0, 1'b0, ST_OK, '0);
            return 1'b1;
         end
         PH_BIN_PAYLOAD: begin
            frame_count++;
            xor_sum = xor_sum ^ b;
            if (frame_count >= lim) begin
               w = end_word(b, ST_TOOLONG);
               return 1'b1;
            end
            if (longint'(frame_count) >= longint'(len_field) + 8) rx_phase = PH_BIN_CHECK;
            w = mk_word(b, 1'b0, 1'b0, ST_OK, '0);
            return 1'b1;
         end
         PH_BIN_CHECK: begin
            frame_count++;
            if (frame_count > lim) begin
               w = end_word(b, ST_TOOLONG);
               return 1'b1;
            end
            w = end_word(b, (b == xor_sum) ? ST_OK : ST_BADSUM);
            return 1'b1;
         end
         default: begin
            clear_frame();
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted byte, checks every accepted word,
   // and stops the run when neither side moves for too long.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_in++;
            pred_has = deframe_byte(req_tdata, pred_w);
            // Directed rows carry their own expectation; the predictor still
            // runs so that its state follows the stream.
            if (cur_typed) begin
               pred_has = cur_want_has;
               pred_w   = cur_want;
            end
            if (pred_has) frame_words = {frame_words, pred_w};
         end

         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            if (rsp_tlast) begin
               if (rsp_tdata[9:8] == ST_OK) n_ok++;
               else if (rsp_tdata[9:8] == ST_BADSUM) n_badsum++;
               else n_toolong++;
            end
            if (frame_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: data %h sof %b eof %b status %0d len %0d",
                           rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[9:8],
                           rsp_tdata[26:10]);
            end else begin
               head_w = frame_words.pop_front();
               if (rsp_tdata[7:0] !== head_w.data || rsp_tuser !== head_w.sof ||
                   rsp_tlast !== head_w.eof || rsp_tdata[9:8] !== head_w.st ||
                   rsp_tdata[26:10] !== head_w.len || rsp_tdata[31:27] !== 5'd0) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("word mismatch: expected data %h sof %b eof %b status %0d len %0d",
                              head_w.data, head_w.sof, head_w.eof, head_w.st, head_w.len);
                     $display("               actual   data %h sof %b eof %b status %0d len %0d pad %h",
                              rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[9:8],
                              rsp_tdata[26:10], rsp_tdata[31:27]);
                  end
               end
            end
         end

         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
               $display("no handshake for %0d cycles, %0d frame words still owed",
                        idle_cycles, frame_words.size());
               $display("stx_etx_or_length_prefixed_deframer test failed");
               $finish;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: holds rsp_tready for random bursts. A hold request from the
   // sender side turns into one long stall counted here.
   // ------------------------------------------------------------------
   initial begin
      int unsigned burst;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            burst = HoldCycles;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            burst = $urandom_range(1, 14);
         end else begin
            rsp_tready <= 1'b1;
            burst = $urandom_range(1, 40);
         end
         repeat (burst - 1) @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender side.
   // ------------------------------------------------------------------

   // Offers one byte and returns once it has been accepted. An optional gap
   // comes first, with tvalid low for its whole length.
   task automatic send_byte(input logic [7:0] b, input bit typed, input bit whas,
                            input frame_word_type want);
      if (tx_idle_on && $urandom_range(0, 11) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid   <= 1'b1;
      req_tdata    <= b;
      cur_typed    = typed;
      cur_want_has = whas;
      cur_want     = want;
      do @(posedge clock); while (!req_tready);
   endtask

   // Lowers tvalid, waits for every owed word, then lets the pipeline run
   // empty so that a byte that made no word is gone as well.
   task automatic drain_frames(input int unsigned extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frame_words.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Register write, only ever issued with the block drained.
   task automatic write_csr(input logic idx, input logic [16:0] val);
      drain_frames(SettleCycles);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CsrProtocolMode) begin
         mode_bin = val[0];
         clear_frame();   // a mode write drops any frame in progress
      end else begin
         max_len_reg = val;
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic row_csr(input logic idx, input logic [16:0] val);
      stim_row_type r;
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.val    = val;
      r.b      = '0;
      r.typed  = 1'b0;
      stim_rows = {stim_rows, r};
   endtask

   // typed 0: predictor decides; typed 1 with whas 0: the byte makes no word.
   task automatic row_byte(input logic [7:0] b, input bit typed, input bit whas,
                           input frame_word_type want);
      stim_row_type r;
      r.is_csr   = 1'b0;
      r.idx      = 1'b0;
      r.val      = '0;
      r.b        = b;
      r.typed    = typed;
      r.want_has = whas;
      r.want     = want;
      stim_rows = {stim_rows, r};
   endtask

   // Fills tx_plan with about target bytes for the mode and limit now set.
   task automatic build_phase(input int unsigned target);
      int unsigned lim;
      int unsigned r;
      int unsigned n;
      int unsigned cap;
      logic [31:0] plen;
      logic [7:0]  sum;
      logic [7:0]  b;
      lim = frame_limit();
      tx_plan.delete();
      while (tx_plan.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // Line noise; any value, so stray starts and magic bytes happen.
            repeat ($urandom_range(1, 6)) tx_plan = {tx_plan, 8'($urandom_range(0, 255))};
         end else if (!mode_bin) begin
            // ASCII frame; some lengths sit right at the limit.
            if (r < 28 && lim <= 64) n = lim - 3 + $urandom_range(0, 4);
            else n = $urandom_range(0, 14);
            tx_plan = {tx_plan, StxByte};
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == EtxByte) b = 8'h83;
               tx_plan = {tx_plan, b};
            end
            tx_plan = {tx_plan, EtxByte};
         end else if (r < 18) begin
            // Magic word broken off before its fourth byte.
            repeat ($urandom_range(1, 3)) tx_plan = {tx_plan, StxByte};
            b = 8'($urandom_range(0, 255));
            if (b == StxByte) b = 8'h82;
            tx_plan = {tx_plan, b};
         end else begin
            if (r < 21) tx_plan = {tx_plan, StxByte};   // one 0x02 too many
            repeat (4) tx_plan = {tx_plan, StxByte};
            cap = (lim - 9 < 12) ? lim - 9 : 12;
            if (r < 25) plen = $urandom;
            else if (r < 30) plen = lim - 9 + $urandom_range(1, 3);
            else if (r < 38) plen = lim - 9 - $urandom_range(0, 1);
            else plen = $urandom_range(0, cap);
            // Larger limits would make boundary frames long; keep them short.
            if (r >= 30 && r < 38 && lim > 64) plen = cap;
            tx_plan = {tx_plan, plen[31:24]};
            tx_plan = {tx_plan, plen[23:16]};
            tx_plan = {tx_plan, plen[15:8]};
            tx_plan = {tx_plan, plen[7:0]};
            if (longint'(plen) + 9 <= longint'(lim)) begin
               sum = '0;
               n = (r >= 95 && plen > 0) ? $urandom_range(0, plen - 1) : plen;
               repeat (n) begin
                  b = 8'($urandom_range(0, 255));
                  sum = sum ^ b;
                  tx_plan = {tx_plan, b};
               end
               // Truncated frames simply run on into the bytes that follow.
               if (n == plen) begin
                  if (r % 5 == 0) tx_plan = {tx_plan, sum ^ 8'($urandom_range(1, 255))};
                  else tx_plan = {tx_plan, sum};
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------
   initial begin
      logic [16:0]  lim_pick;
      stim_row_type row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = CsrProtocolMode;
      csr_wdata  = '0;
      cur_typed  = 1'b0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      hold_req   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. ASCII mode after reset: a dropped byte, a short frame
      // with a zero payload byte, then a frame cut off by a mode write.
      row_byte(8'hFF, 1'b1, 1'b0, no_word);
      row_byte(StxByte, 1'b1, 1'b1, mk_word(StxByte, 1'b1, 1'b0, ST_OK, 17'd0));
      row_byte(8'h00, 1'b0, 1'b0, no_word);
      row_byte(EtxByte, 1'b1, 1'b1, mk_word(EtxByte, 1'b0, 1'b1, ST_OK, 17'd3));
      row_byte(StxByte, 1'b1, 1'b1, mk_word(StxByte, 1'b1, 1'b0, ST_OK, 17'd0));
      row_byte(8'h41, 1'b0, 1'b0, no_word);
      row_csr(CsrProtocolMode, 17'd1);
      // Binary mode: empty payload whose checksum byte is wrong.
      repeat (3) row_byte(StxByte, 1'b1, 1'b0, no_word);
      row_byte(StxByte, 1'b1, 1'b1, mk_word(StxByte, 1'b1, 1'b0, ST_OK, 17'd0));
      repeat (3) row_byte(8'h00, 1'b0, 1'b0, no_word);
      row_byte(8'h00, 1'b1, 1'b1, mk_word(8'h00, 1'b0, 1'b0, ST_OK, 17'd0));
      row_byte(8'hFF, 1'b1, 1'b1, mk_word(8'hFF, 1'b0, 1'b1, ST_BADSUM, 17'd9));
      // Smallest limit: a payload of 8 cannot fit, so the frame ends on the
      // last length byte.
      row_csr(CsrMaxFrameLen, 17'd16);
      repeat (3) row_byte(StxByte, 1'b1, 1'b0, no_word);
      row_byte(StxByte, 1'b1, 1'b1, mk_word(StxByte, 1'b1, 1'b0, ST_OK, 17'd0));
      repeat (3) row_byte(8'h00, 1'b0, 1'b0, no_word);
      row_byte(8'h08, 1'b1, 1'b1, mk_word(8'h08, 1'b0, 1'b1, ST_TOOLONG, 17'd8));

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         if (row.is_csr) write_csr(row.idx, row.val);
         else send_byte(row.b, row.typed, row.want_has, row.want);
      end

      // Random phases. Every fourth phase changes only the limit, so it takes
      // effect in the middle of whatever frame the parser is in.
      for (int p = 0; p < PhaseCount; p++) begin
         case (p)
            0:       lim_pick = 17'd16;
            1:       lim_pick = 17'd0;        // below the floor
            2:       lim_pick = 17'd131071;   // above the ceiling
            3:       lim_pick = 17'd65536;
            4:       lim_pick = 17'd17;
            default: lim_pick = 17'($urandom_range(16, 60));
         endcase
         if (p % 4 != 3) write_csr(CsrProtocolMode, 17'(p % 2));
         write_csr(CsrMaxFrameLen, lim_pick);
         tx_idle_on = (p != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
         rx_idle_on = (p != PhaseCount - 1);
         build_phase(PhaseBytes);
         // Long receiver stall while the sender keeps offering bytes.
         if (p == 2) hold_req = 1'b1;
         foreach (tx_plan[i]) begin
            // Once, the sender stops until every owed word is back.
            if (p == 5 && i == tx_plan.size() / 2) drain_frames(0);
            send_byte(tx_plan[i], 1'b0, 1'b0, no_word);
         end
      end

      drain_frames(4 * SettleCycles);

      $display("ran %0d received bytes in both modes and %0d limits; %0d frame words out",
               bytes_in, PhaseCount + 1, words_out);
      $display("frames ended: %0d ok, %0d bad checksum, %0d too long; %0d mismatches",
               n_ok, n_badsum, n_toolong, mismatches);
      if (mismatches == 0) begin
         $display("stx_etx_or_length_prefixed_deframer test passed");
      end else begin
         $display("stx_etx_or_length_prefixed_deframer test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sedf_pkg.sv
rtl/sedf_parser.sv
rtl/stx_etx_or_length_prefixed_deframer.sv
rtl/sedf_checker.sv
tb/tb.sv
